// ===== src/skbm_pkg.sv =====
// Shared types and constants for the sorted key/bit map.
package skbm_pkg;

  localparam int Capacity = 64;
  localparam int PosW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    ACT_GET       = 4'd0,
    ACT_PUT       = 4'd1,
    ACT_DELETE    = 4'd2,
    ACT_APPEND    = 4'd3,
    ACT_REMOVE_AT = 4'd4,
    ACT_KEY_AT    = 4'd5,
    ACT_VALUE_AT  = 4'd6,
    ACT_SET_AT    = 4'd7,
    ACT_INDEX_KEY = 4'd8,
    ACT_INDEX_VAL = 4'd9,
    ACT_CLEAR     = 4'd10
  } action_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] key;
    logic               value;
    logic               default_value;
    logic [5:0]         position;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic               value_out;
    logic signed [31:0] key_out;
    logic signed [7:0]  index_out;
    logic [6:0]         count_out;
    logic [1:0]         status;
  } out_beat_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        shift_in;   // cells above pos take left neighbour, cell at pos takes key
    logic        shift_out;  // cells at or above pos take right neighbour
    logic        write_val;  // cell at pos takes value
    logic [31:0] key;
    logic        value;
    logic [PosW-1:0] pos;
  } cell_cmd_t;

endpackage

// ===== src/skbm_cell.sv =====
// One table entry: holds a key and a bit, compares and shifts with neighbours.
module skbm_cell (
  input  logic                    clk,
  input  logic [skbm_pkg::PosW-1:0] idx,
  input  skbm_pkg::cell_cmd_t     cmd,
  input  logic [31:0]             key_left,
  input  logic                    bit_left,
  input  logic [31:0]             key_right,
  input  logic                    bit_right,
  input  logic [31:0]             probe_key,
  output logic [31:0]             key_q,
  output logic                    bit_q,
  output logic                    less,
  output logic                    equal
);
  import skbm_pkg::*;

  logic [31:0] key_r;
  logic        bit_r;

  always_ff @(posedge clk) begin
    if (cmd.shift_in && idx > cmd.pos) begin
      key_r <= key_left;
      bit_r <= bit_left;
    end else if (cmd.shift_in && idx == cmd.pos) begin
      key_r <= cmd.key;
      bit_r <= cmd.value;
    end else if (cmd.shift_out && idx >= cmd.pos) begin
      key_r <= key_right;
      bit_r <= bit_right;
    end else if (cmd.write_val && idx == cmd.pos) begin
      bit_r <= cmd.value;
    end
  end

  assign key_q = key_r;
  assign bit_q = bit_r;
  assign less  = $signed(key_r) < $signed(probe_key);
  assign equal = key_r == probe_key;
endmodule

// ===== src/sorted_key_bit_map.sv =====
// Top level of the sorted key/bit map: controller and row of cells.
//
//   channel | direction | payload
//   in_     | input     | in_beat_t  (action, key, value, default_value, position)
//   out_    | output    | out_beat_t (found, value_out, key_out, index_out, count_out, status)
//
// Cells compare in the accept cycle (registered); the next cycle resolves the
// search, shifts the row and loads the result; no new item is taken meanwhile.
// Reset empties the table at once; entries are read only once written.
// A stalled result holds; a new item is taken once the result register frees.
module sorted_key_bit_map (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skbm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skbm_pkg::out_beat_t out_data
);
  import skbm_pkg::*;

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_EXEC = 2'b10} state_t;

  state_t          state_r, state_nxt;
  in_beat_t        item_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic            ovalid_r;
  out_beat_t       out_r, res;
  cell_cmd_t       cmd;

  logic [31:0]         keys [Capacity];
  logic [Capacity-1:0] bits, lt, eq, lt_r, eq_r;

  logic in_acc;
  assign in_stall = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [31:0] kl, kr;
    logic        bl, br;
    if (g == 0) begin : g_l0
      assign kl = '0;
      assign bl = 1'b0;
    end else begin : g_ln
      assign kl = keys[g-1];
      assign bl = bits[g-1];
    end
    if (g == Capacity - 1) begin : g_rn
      assign kr = '0;
      assign br = 1'b0;
    end else begin : g_r
      assign kr = keys[g+1];
      assign br = bits[g+1];
    end
    skbm_cell u_cell (
      .clk      (clk),
      .idx      (PosW'(g)),
      .cmd      (cmd),
      .key_left (kl),
      .bit_left (bl),
      .key_right(kr),
      .bit_right(br),
      .probe_key(in_data.key),
      .key_q    (keys[g]),
      .bit_q    (bits[g]),
      .less     (lt[g]),
      .equal    (eq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
      lt_r   <= lt;
      eq_r   <= eq;
    end
  end

  // Search: live keys are sorted, so the insertion point is the first live
  // cell not below the key.
  logic [CntW-1:0] ins_pt, hit_pos, val_pos;
  logic            hit, val_hit;
  always_comb begin
    ins_pt  = count_r;
    hit     = 1'b0;
    hit_pos = '0;
    val_hit = 1'b0;
    val_pos = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (CntW'(i) < count_r && eq_r[i]) begin
        hit     = 1'b1;
        hit_pos = CntW'(i);
      end
    end
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (CntW'(i) < count_r && !lt_r[i]) begin
        ins_pt = CntW'(i);
      end
      if (CntW'(i) < count_r && bits[i] == item_r.value) begin
        val_hit = 1'b1;
        val_pos = CntW'(i);
      end
    end
  end

  logic [CntW-1:0] p_ext;
  logic            pos_ok, full;
  logic [CntW-1:0] spos;
  assign p_ext  = CntW'(item_r.position);
  assign pos_ok = p_ext < count_r;
  assign full   = count_r >= CntW'(Capacity);
  assign spos   = hit ? hit_pos : ins_pt;

  always_comb begin
    logic exec;
    exec      = state_r == S_EXEC;
    res       = '0;
    cmd       = '0;
    cmd.key   = item_r.key;
    cmd.value = item_r.value;
    count_nxt = count_r;
    unique case (item_r.action)
      ACT_GET, ACT_PUT, ACT_DELETE, ACT_APPEND, ACT_INDEX_KEY: begin
        res.found     = hit;
        res.index_out = hit ? 8'(spos) : ~8'(spos);
        cmd.pos       = PosW'(spos);
        if (item_r.action == ACT_GET) begin
          res.value_out = hit ? bits[PosW'(spos)] : item_r.default_value;
        end else if (item_r.action == ACT_DELETE) begin
          if (hit) begin
            cmd.shift_out = exec;
            count_nxt     = count_r - 1'b1;
          end
        end else if (item_r.action != ACT_INDEX_KEY) begin
          if (hit) begin
            cmd.write_val = exec;
          end else if (full) begin
            res.status = ST_FULL;
          end else begin
            cmd.shift_in = exec;
            count_nxt    = count_r + 1'b1;
          end
        end
      end
      ACT_REMOVE_AT, ACT_KEY_AT, ACT_VALUE_AT, ACT_SET_AT: begin
        cmd.pos = PosW'(item_r.position);
        if (!pos_ok) begin
          res.status    = ST_RANGE;
          res.index_out = -8'sd1;
        end else begin
          res.found     = 1'b1;
          res.index_out = 8'(item_r.position);
          if (item_r.action == ACT_REMOVE_AT) begin
            cmd.shift_out = exec;
            count_nxt     = count_r - 1'b1;
          end else if (item_r.action == ACT_KEY_AT) begin
            res.key_out = keys[PosW'(item_r.position)];
          end else if (item_r.action == ACT_VALUE_AT) begin
            res.value_out = bits[PosW'(item_r.position)];
          end else begin
            cmd.write_val = exec;
          end
        end
      end
      ACT_INDEX_VAL: begin
        res.found     = val_hit;
        res.index_out = val_hit ? 8'(val_pos) : -8'sd1;
      end
      ACT_CLEAR: count_nxt = '0;
      default: ;
    endcase
    res.count_out = 7'(count_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        count_r  <= count_nxt;
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) out_r <= res;
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Capacity)) else $error("count above capacity");
  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE) else $error("exec overran");
  a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !cmd.shift_in && !cmd.shift_out && !cmd.write_val)
    else $error("cell write while idle");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the sorted key/bit map: directed table, fill and overflow, then random actions.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import skbm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_key_bit_map u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic signed [31:0] map_keys[Capacity];
  logic               map_bits[Capacity];
  int                 map_count;

  out_beat_t pending[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic out_beat_t predict_map(input in_beat_t b);
    out_beat_t r;
    int lo, hi, mid, pos, i;
    bit hit;
    r = '0;
    hit = 1'b0;
    lo = 0;
    hi = map_count;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (map_keys[mid] < b.key) lo = mid + 1;
      else if (map_keys[mid] == b.key) begin
        hit = 1'b1;
        lo = mid;
      end else hi = mid;
    end
    pos = lo;
    case (b.action)
      ACT_GET, ACT_PUT, ACT_DELETE, ACT_APPEND, ACT_INDEX_KEY: begin
        r.found = hit;
        r.index_out = hit ? 8'(pos) : ~8'(pos);
        if (b.action == ACT_GET) begin
          r.value_out = hit ? map_bits[pos] : b.default_value;
        end else if (b.action == ACT_DELETE) begin
          if (hit) begin
            for (i = pos; i < map_count - 1; i++) begin
              map_keys[i] = map_keys[i+1];
              map_bits[i] = map_bits[i+1];
            end
            map_count--;
          end
        end else if (b.action != ACT_INDEX_KEY) begin
          if (hit) map_bits[pos] = b.value;
          else if (map_count >= Capacity) r.status = ST_FULL;
          else begin
            for (i = map_count; i > pos; i--) begin
              map_keys[i] = map_keys[i-1];
              map_bits[i] = map_bits[i-1];
            end
            map_keys[pos] = b.key;
            map_bits[pos] = b.value;
            map_count++;
          end
        end
      end
      ACT_REMOVE_AT, ACT_KEY_AT, ACT_VALUE_AT, ACT_SET_AT: begin
        if (int'(b.position) >= map_count) begin
          r.status = ST_RANGE;
          r.index_out = -8'sd1;
        end else begin
          r.found = 1'b1;
          r.index_out = 8'(b.position);
          case (b.action)
            ACT_REMOVE_AT: begin
              for (i = int'(b.position); i < map_count - 1; i++) begin
                map_keys[i] = map_keys[i+1];
                map_bits[i] = map_bits[i+1];
              end
              map_count--;
            end
            ACT_KEY_AT: r.key_out = map_keys[b.position];
            ACT_VALUE_AT: r.value_out = map_bits[b.position];
            default: map_bits[b.position] = b.value;
          endcase
        end
      end
      ACT_INDEX_VAL: begin
        r.index_out = -8'sd1;
        for (i = 0; i < map_count; i++) begin
          if (map_bits[i] == b.value) begin
            r.index_out = 8'(i);
            r.found = 1'b1;
            break;
          end
        end
      end
      ACT_CLEAR: map_count = 0;
      default: ;
    endcase
    r.count_out = 7'(map_count);
    return r;
  endfunction

  // directed rows; fixed expectations checked against predictor too
  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t want;
  } row_t;

  function automatic in_beat_t mk(input logic [3:0] a, input logic signed [31:0] k,
                                  input logic v, input logic d, input logic [5:0] p);
    in_beat_t b;
    b.action = a; b.key = k; b.value = v; b.default_value = d; b.position = p;
    return b;
  endfunction

  function automatic out_beat_t ob(input logic f, input logic v, input logic signed [7:0] ix,
                                   input logic [6:0] c, input logic [1:0] s);
    out_beat_t o;
    o = '0;
    o.found = f; o.value_out = v; o.index_out = ix; o.count_out = c; o.status = s;
    return o;
  endfunction

  row_t rows[$];

  function automatic in_beat_t rand_beat(input int span);
    in_beat_t b;
    int pick;
    b = '0;
    b.value = 1'($urandom);
    b.default_value = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) b.action = ACT_PUT;
    else if (pick < 40) b.action = ACT_APPEND;
    else if (pick < 52) b.action = ACT_GET;
    else if (pick < 60) b.action = ACT_DELETE;
    else if (pick < 64) b.action = ACT_REMOVE_AT;
    else if (pick < 70) b.action = ACT_KEY_AT;
    else if (pick < 75) b.action = ACT_VALUE_AT;
    else if (pick < 80) b.action = ACT_SET_AT;
    else if (pick < 87) b.action = ACT_INDEX_KEY;
    else if (pick < 93) b.action = ACT_INDEX_VAL;
    else if (pick < 95) b.action = ACT_CLEAR;
    else b.action = 4'($urandom_range(11, 15));
    if ($urandom_range(0, 4) == 0) b.key = $urandom;
    else b.key = $signed($urandom_range(0, span)) - span / 2;
    if (b.action == ACT_APPEND && map_count > 0 && $urandom_range(0, 1))
      b.key = map_keys[map_count-1] + $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) b.position = 6'($urandom);
    else b.position = 6'($urandom_range(0, map_count > 0 ? map_count : 0));
    return b;
  endfunction

  // valid stays high across back-to-back beats; offer drops it only for a gap
  task automatic offer(input in_beat_t b, input out_beat_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending.push_back(w);
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send(input in_beat_t b);
    offer(b, predict_map(b));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    out_beat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report("unexpected beat", 64'(out_data), 64'd0);
      end else begin
        w = pending.pop_front();
        if (out_data.found !== w.found) report("found", out_data.found, w.found);
        if (out_data.value_out !== w.value_out)
          report("value_out", out_data.value_out, w.value_out);
        if (out_data.key_out !== w.key_out) report("key_out", out_data.key_out, w.key_out);
        if (out_data.index_out !== w.index_out)
          report("index_out", out_data.index_out, w.index_out);
        if (out_data.count_out !== w.count_out)
          report("count_out", out_data.count_out, w.count_out);
        if (out_data.status !== w.status) report("status", out_data.status, w.status);
      end
    end
  end

  initial begin : receiver
    int hold;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      hold = $urandom_range(0, 2) == 0 ? $urandom_range(0, 13) : 0;
      if (cycles > 30000 && cycles < 34000) hold = 0;
      out_stall <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : sender
    out_beat_t w;
    int i;
    map_count = 0;
    // empty table
    rows.push_back('{mk(ACT_GET, 32'sd5, 1'b0, 1'b1, 6'd0), 1, ob(0, 1, -8'sd1, 0, ST_OK)});
    rows.push_back('{mk(ACT_KEY_AT, 32'sd0, 1'b0, 1'b0, 6'd0), 1, ob(0, 0, -8'sd1, 0, ST_RANGE)});
    rows.push_back('{mk(ACT_INDEX_VAL, 32'sd0, 1'b1, 1'b0, 6'd0), 1, ob(0, 0, -8'sd1, 0, ST_OK)});
    rows.push_back('{mk(ACT_PUT, 32'sh80000000, 1'b1, 1'b0, 6'd0), 1, ob(0, 0, -8'sd1, 1, ST_OK)});
    rows.push_back('{mk(ACT_PUT, 32'sh7fffffff, 1'b0, 1'b0, 6'd0), 1, ob(0, 0, -8'sd2, 2, ST_OK)});
    rows.push_back('{mk(ACT_PUT, 32'sd0, 1'b1, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_PUT, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_APPEND, -32'sd1, 1'b1, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_GET, 32'sh7fffffff, 1'b0, 1'b1, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_INDEX_KEY, 32'sd3, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_KEY_AT, 32'sd0, 1'b0, 1'b0, 6'd3), 0, '0});
    rows.push_back('{mk(ACT_VALUE_AT, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_SET_AT, 32'sd0, 1'b1, 1'b0, 6'd2), 0, '0});
    rows.push_back('{mk(ACT_INDEX_VAL, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_VALUE_AT, 32'sd0, 1'b0, 1'b0, 6'd63), 0, '0});
    rows.push_back('{mk(ACT_DELETE, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_DELETE, 32'sd77, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_REMOVE_AT, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(4'd15, 32'shffffffff, 1'b1, 1'b1, 6'd63), 0, '0});
    rows.push_back('{mk(ACT_CLEAR, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    rows.push_back('{mk(ACT_GET, 32'sd0, 1'b0, 1'b0, 6'd0), 0, '0});
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[r]) begin
      if (rows[r].fixed) begin
        w = predict_map(rows[r].beat);
        if (w !== rows[r].want) report("directed row", 64'(w), 64'(rows[r].want));
        offer(rows[r].beat, rows[r].want);
      end else begin
        send(rows[r].beat);
      end
    end
    // fill to capacity and overflow
    for (i = 0; i < Capacity + 3; i++)
      send(mk(ACT_APPEND, 32'(i * 3 - 50), 1'($urandom), 1'b0, 6'd0));
    send(mk(ACT_PUT, 32'sd1000001, 1'b1, 1'b0, 6'd0));
    send(mk(ACT_KEY_AT, 32'sd0, 1'b0, 1'b0, 6'd63));
    send(mk(ACT_INDEX_KEY, 32'sh7fffffff, 1'b0, 1'b0, 6'd0));
    long_hold = 1'b1;
    for (i = 0; i < 20; i++) send(rand_beat(400));
    drain();
    repeat (20) @(posedge clk);
    for (i = 0; i < 340; i++) send(rand_beat(i < 170 ? 60 : 400));
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
